// ===== rtl/mrr_pkg.sv =====
`default_nettype none
package mrr_pkg;

    // Working width of the arithmetic; fixed, since the transfer fields are fixed.
    localparam int NUM_WIDTH = 31;
    localparam int FIELD_W   = 31;

    typedef struct packed {
        logic [FIELD_W-1:0] candidate;
        logic [FIELD_W-1:0] random_word;
    } t_in;

    typedef struct packed {
        logic probably_prime;
        logic corner_case;
    } t_out;

    // Datapath operations selected by the controller.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_SHIFT = 3'd2,
        OP_RSEED = 3'd3,
        OP_MUL   = 3'd4,
        OP_SQR   = 3'd5,
        OP_STEP  = 3'd6,
        OP_COPY  = 3'd7
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic small_n;
        logic small_prime;
        logic d_odd;
        logic e_zero;
        logic e_bit;
        logic busy;
        logic x_one;
        logic x_nm1;
        logic r_left;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/mrr_datapath.sv =====
`default_nettype none
module mrr_datapath
    import mrr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_in     i_data,
    input  wire t_cmd    i_cmd,
    output t_status      o_status
);
    localparam int W  = NUM_WIDTH;
    localparam int PW = 2 * NUM_WIDTH;
    localparam int CW = $clog2(PW + 1);
    localparam int RW = $clog2(NUM_WIDTH + 1);

    logic [W-1:0]  r_n, r_d, r_b, r_acc, r_x, r_rnd;
    logic [RW-1:0] r_r;
    // Shared restoring remainder unit: one dividend bit per cycle.
    logic [PW-1:0] r_dvd;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    t_op           r_op;

    logic [W-1:0]  n_cand;
    logic [W:0]    w_shift, w_diff;
    logic [W-1:0]  w_opa, w_opb;
    logic [PW-1:0] w_prod, w_dvd_in;
    logic [W-1:0]  w_nm1;

    assign n_cand  = i_data.candidate[W-1:0];
    assign w_nm1   = r_n - {{(W-1){1'b0}}, 1'b1};
    assign w_shift = {r_rem[W-1:0], r_dvd[PW-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    // Multiplier operand choice for the next remainder pass.
    always_comb begin
        w_opa = r_b;
        w_opb = r_b;
        case (i_cmd.op)
            OP_MUL: begin
                w_opa = r_acc;
                w_opb = r_b;
            end
            OP_STEP: begin
                w_opa = r_x;
                w_opb = r_x;
            end
            default: begin
            end
        endcase
    end

    assign w_prod   = {{W{1'b0}}, w_opa} * {{W{1'b0}}, w_opb};
    assign w_dvd_in = (i_cmd.op == OP_RSEED) ? {{W{1'b0}}, r_rnd} : w_prod;

    // Operand registers and the serial remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_NONE;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[PW-2:0], 1'b0};
            r_rem <= w_diff[W] ? w_shift : w_diff;
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end else if (i_cmd.start) begin
            r_op   <= i_cmd.op;
            r_dvd  <= w_dvd_in;
            r_rem  <= '0;
            r_div  <= (i_cmd.op == OP_RSEED) ? r_n - W'(4) : r_n;
            r_cnt  <= CW'(PW);
            r_busy <= 1'b1;
        end else if (r_op != OP_NONE) begin
            // Write back the finished remainder once.
            case (r_op)
                OP_RSEED: r_b <= r_rem[W-1:0] + W'(2);
                OP_MUL:   r_acc <= r_rem[W-1:0];
                OP_SQR: begin
                    r_b <= r_rem[W-1:0];
                    r_d <= {1'b0, r_d[W-1:1]};
                end
                OP_STEP: begin
                    r_x <= r_rem[W-1:0];
                    r_r <= r_r - RW'(1);
                end
                default: begin
                end
            endcase
            r_op <= OP_NONE;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_n   <= n_cand;
                    r_d   <= n_cand - {{(W-1){1'b0}}, 1'b1};
                    r_rnd <= i_data.random_word[W-1:0];
                    r_r   <= '0;
                    r_acc <= {{(W-1){1'b0}}, 1'b1};
                end
                OP_SHIFT: begin
                    r_d <= {1'b0, r_d[W-1:1]};
                    r_r <= r_r + RW'(1);
                end
                OP_COPY: begin
                    r_x <= r_acc;
                end
                default: begin
                end
            endcase
        end
    end

    // Status for the controller.
    always_comb begin
        o_status.small_n     = (r_n <= W'(4));
        o_status.small_prime = (r_n == W'(2)) || (r_n == W'(3));
        o_status.d_odd       = r_d[0];
        o_status.e_zero      = (r_d == '0);
        o_status.e_bit       = r_d[0];
        o_status.busy        = r_busy || (r_op != OP_NONE);
        o_status.x_one       = (r_x == {{(W-1){1'b0}}, 1'b1});
        o_status.x_nm1       = (r_x == w_nm1);
        o_status.r_left      = (r_r > RW'(1));
    end

`ifndef SYNTHESIS
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("remainder count zero while busy");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CW'(1)) |=> (r_rem <= {1'b0, r_div}))
        else $error("remainder not reduced");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && !r_busy) |=> r_busy)
        else $error("start ignored");
`endif
endmodule
`default_nettype wire

// ===== rtl/mrr_control.sv =====
`default_nettype none
module mrr_control
    import mrr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_out         o_data,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLASS = 10'b0000000010,
        S_STRIP = 10'b0000000100,
        S_SEED  = 10'b0000001000,
        S_POW   = 10'b0000010000,
        S_SQW   = 10'b0000100000,
        S_MULW  = 10'b0001000000,
        S_CHK   = 10'b0010000000,
        S_LOOPW = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_wait;
    t_out   r_res, n_res;
    t_out   r_out, n_out;
    logic   r_full, n_full;

    // Sequencer for one candidate at a time.
    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_out     = r_out;
        n_full    = r_full;
        o_cmd.op    = OP_NONE;
        o_cmd.start = 1'b0;
        if (r_full && !i_stall) begin
            n_full = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_status.small_n) begin
                    n_res.probably_prime = i_status.small_prime;
                    n_res.corner_case    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                if (i_status.d_odd) begin
                    o_cmd.op = OP_RSEED; o_cmd.start = 1'b1;
                    n_state  = S_SEED;
                end else begin
                    o_cmd.op = OP_SHIFT;
                end
            end
            S_SEED: begin
                if (!i_status.busy) begin
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (i_status.e_zero) begin
                    // The power is complete; x takes the accumulated value.
                    o_cmd.op = OP_COPY;
                    n_state  = S_CHK;
                end else if (i_status.e_bit && !r_wait) begin
                    o_cmd.op = OP_MUL; o_cmd.start = 1'b1;
                    n_state  = S_MULW;
                end else begin
                    o_cmd.op = OP_SQR; o_cmd.start = 1'b1;
                    n_state  = S_SQW;
                end
            end
            S_MULW: begin
                if (!i_status.busy) begin
                    n_state = S_POW;
                end
            end
            S_SQW: begin
                if (!i_status.busy) begin
                    n_state = S_POW;
                end
            end
            S_CHK: begin
                if (i_status.x_one || i_status.x_nm1) begin
                    n_res.probably_prime = i_status.x_nm1 || !r_wait;
                    n_res.corner_case    = 1'b0;
                    n_state = S_DONE;
                end else if (i_status.r_left) begin
                    o_cmd.op = OP_STEP; o_cmd.start = 1'b1;
                    n_state  = S_LOOPW;
                end else begin
                    n_res   = '{probably_prime: 1'b0, corner_case: 1'b0};
                    n_state = S_DONE;
                end
            end
            S_LOOPW: begin
                if (!i_status.busy) begin
                    n_state = S_CHK;
                end
            end
            S_DONE: begin
                // Move the verdict into the output register once it is free.
                if (!r_full || !i_stall) begin
                    n_out   = r_res;
                    n_full  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // r_wait marks that the multiply for the current exponent bit is done,
    // and later that squaring has begun (x of one then means composite).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full  <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_full  <= n_full;
            if (r_state == S_IDLE) begin
                r_wait <= 1'b0;
            end else if (r_state == S_MULW && !i_status.busy) begin
                r_wait <= 1'b1;
            end else if (r_state == S_SQW && !i_status.busy) begin
                r_wait <= 1'b0;
            end else if (r_state == S_LOOPW) begin
                r_wait <= 1'b1;
            end else if (r_state == S_POW && i_status.e_zero) begin
                r_wait <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_full;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_CLASS))
        else $error("transfer not taken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("result changed while stalled");
    a_no_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_full && i_stall) |=> (r_state == S_DONE))
        else $error("result overwritten");
`endif
endmodule
`default_nettype wire

// ===== rtl/miller_rabin_round.sv =====
`default_nettype none
// One Miller-Rabin round per input transfer. Candidates up to four are decided
// by fixed rules. Otherwise the block strips twos from n-1 one factor at a time,
// forms the witness and runs square-and-multiply. Every modular product goes
// through one shared restoring remainder unit that steps through all
// 2*NUM_WIDTH dividend bits and then writes the remainder back. An item needs
// up to about 62 products (witness, multiplies, squares and the final
// squarings). One item is in work at a time; the result waits in an output
// register while the next item is accepted, and the input stalls whenever an
// item is in work, also while its verdict waits for that register to be free.
module miller_rabin_round
    import mrr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);
    t_cmd    w_cmd;
    t_status w_status;

    mrr_control u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mrr_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );
endmodule
`default_nettype wire

// ===== bench/miller_rabin_round_test.sv =====
module miller_rabin_round_test;
    import mrr_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 240;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    miller_rabin_round dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data(o_data)
    );

    // One row of the directed table; has_verdict marks rows typed in by hand.
    typedef struct {
        logic [30:0] n;
        logic [30:0] w;
        bit          has_verdict;
        t_out        verdict;
    } t_row;

    t_out verdict_queue[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   sending_done = 0;
    bit   hold_off = 0;
    bit   hold_off_done = 0;

    // Clock generation.
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Modular product at double width.
    function automatic logic [30:0] mul_mod(logic [30:0] x, logic [30:0] y, logic [30:0] m);
        logic [63:0] p;
        p = {33'd0, x} * {33'd0, y};
        return 31'(p % {33'd0, m});
    endfunction

    // Computes the verdict of one round for candidate n and random word w.
    function automatic t_out round_verdict(logic [30:0] n, logic [30:0] w);
        t_out        res;
        logic [30:0] d, a, x, b, nm1;
        int          r;
        res.probably_prime = 0;
        res.corner_case = 0;
        if (n <= 1 || n == 4) begin
            res.corner_case = 1;
            return res;
        end
        if (n <= 3) begin
            res.probably_prime = 1;
            res.corner_case = 1;
            return res;
        end
        nm1 = n - 1;
        d = nm1;
        r = 0;
        while (d[0] == 0) begin
            d = d >> 1;
            r++;
        end
        a = 2 + (w % (n - 4));
        x = 1;
        b = a % n;
        while (d != 0) begin
            if (d[0]) x = mul_mod(x, b, n);
            d = d >> 1;
            b = mul_mod(b, b, n);
        end
        if (x == 1 || x == nm1) begin
            res.probably_prime = 1;
        end else begin
            for (int i = 1; i < r; i++) begin
                x = mul_mod(x, x, n);
                if (x == 1) break;
                if (x == nm1) begin
                    res.probably_prime = 1;
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Offers one item and waits for its transfer; gaps are mostly short.
    task automatic send_item(logic [30:0] n, logic [30:0] w, bit typed, t_out given);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1;
        i_data <= '{candidate: n, random_word: w};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        verdict_queue.push_back(typed ? given : round_verdict(n, w));
        @(negedge i_clk);
    endtask

    // Random candidate: mostly small or odd, sometimes the prime 2^31-1 or odd k*2^15+1.
    function automatic logic [30:0] pick_candidate();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 40));
            1: return 31'($urandom_range(0, 2000)) | 31'd1;
            2: return 31'($urandom) | 31'd1;
            3: return 31'($urandom);
            4: return 31'h7FFFFFFF;
            default: return (31'($urandom_range(1, 65535)) << 15) | 31'd1;
        endcase
    endfunction

    // Stimulus: directed table, then random items.
    initial begin
        t_row rows[$];
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        rows = '{
            '{0, 0, 1, '{0, 1}},
            '{1, 31'h7FFFFFFF, 1, '{0, 1}},
            '{2, 5, 1, '{1, 1}},
            '{3, 31'h7FFFFFFF, 1, '{1, 1}},
            '{4, 9, 1, '{0, 1}},
            '{5, 31'h7FFFFFFF, 1, '{1, 0}},
            '{6, 0, 1, '{0, 0}},
            '{7, 0, 0, '{0, 0}},
            '{9, 1, 0, '{0, 0}},
            '{561, 31'h55555555, 0, '{0, 0}},
            '{31'h7FFFFFFF, 0, 1, '{1, 0}},
            '{31'h7FFFFFFF, 31'h7FFFFFFF, 1, '{1, 0}},
            '{31'h7FFFFFFE, 31'h2AAAAAAA, 0, '{0, 0}},
            '{31'h7FFFFFFD, 31'h12345678, 0, '{0, 0}},
            '{65537, 31'h7FFFFFF0, 1, '{1, 0}},
            '{1024, 77, 0, '{0, 0}},
            '{2047, 3, 0, '{0, 0}},
            '{97, 31'h40000000, 1, '{1, 0}}
        };
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;
        foreach (rows[k])
            send_item(rows[k].n, rows[k].w, rows[k].has_verdict, rows[k].verdict);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 40) hold_off = 1;
            send_item(pick_candidate(), 31'($urandom), 0, '{0, 0});
        end
        i_valid <= 0;
        sending_done = 1;
    end

    // Receiver stall: random gaps, plus one long hold-off.
    initial begin
        i_stall = 1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off && !hold_off_done) begin
                i_stall <= 1;
                repeat (20000) @(negedge i_clk);
                hold_off_done = 1;
            end
            if ($urandom_range(0, 2) == 0) begin
                i_stall <= 1;
                repeat (($urandom_range(0, 15) == 0) ? $urandom_range(50, 300)
                        : $urandom_range(1, 3)) @(negedge i_clk);
            end
            i_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    // Result check and watchdog.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (hold_off && !hold_off_done))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (verdict_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    want = verdict_queue.pop_front();
                    if (o_data.probably_prime !== want.probably_prime)
                        report_mismatch("probably_prime", o_data.probably_prime,
                                        want.probably_prime);
                    if (o_data.corner_case !== want.corner_case)
                        report_mismatch("corner_case", o_data.corner_case,
                                        want.corner_case);
                end
            end
        end
    end

    // End of run.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("miller_rabin_round test failed");
                $finish;
            end
            if (sending_done && verdict_queue.size() == 0) begin
                repeat (100) @(posedge i_clk);
                if (error_count == 0 && verdict_queue.size() == 0)
                    $display("miller_rabin_round test passed");
                else
                    $display("miller_rabin_round test failed");
                $finish;
            end
        end
    end

endmodule
